// ===== sv/c5sa_pkg.sv =====
`default_nettype none
package c5sa_pkg;

  // payload field widths
  localparam int FUNC_W     = 2;
  localparam int ICH_W      = 3;
  localparam int OCH_W      = 4;
  localparam int POS_W      = 5;
  localparam int TAP_W      = 3;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 32;
  localparam int RES_W      = 64;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int IMG_W      = 6;
  localparam int NIN_W      = 4;
  localparam int NOUT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_EN    = 2'd3;

  localparam logic [IMG_W-1:0]  RST_IMAGE_WIDTH  = 6'd28;
  localparam logic [NIN_W-1:0]  RST_IN_CHANNELS  = 4'd1;
  localparam logic [NOUT_W-1:0] RST_OUT_CHANNELS = 5'd5;
  localparam logic              RST_SQUARE_EN    = 1'b1;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_PIXEL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE     = 2'd2;

  // kernel geometry
  localparam int KSIZE = 5;
  localparam int KPAD  = 2;

  // largest magnitude whose square fits in a signed 64-bit value
  localparam logic [RES_W-1:0] SQ_LIMIT  = 64'd3037000499;
  localparam logic [RES_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SQ,
    ST_MUL,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic clear;     // start of a new sum
    logic issue;     // a tap read was issued this cycle
    logic in_image;  // the issued tap lies inside the image
    logic sq;        // take the magnitude of the finished sum
    logic mul;       // square and select the result
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/c5sa_if.sv =====
`default_nettype none
interface c5sa_in_if import c5sa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [ICH_W-1:0]         in_chan;
  logic [OCH_W-1:0]         out_chan;
  logic [POS_W-1:0]         row;
  logic [POS_W-1:0]         col;
  logic [TAP_W-1:0]         tap_row;
  logic [TAP_W-1:0]         tap_col;
  logic signed [DATA_W-1:0] data_value;

  modport source (
    output valid, func, in_chan, out_chan, row, col, tap_row, tap_col, data_value,
    input  ready
  );
  modport sink (
    input  valid, func, in_chan, out_chan, row, col, tap_row, tap_col, data_value,
    output ready
  );
endinterface

interface c5sa_out_if import c5sa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic                    range_error;

  modport source (
    output valid, result_value, range_error,
    input  ready
  );
  modport sink (
    input  valid, result_value, range_error,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/c5sa_ram.sv =====
`default_nettype none
module c5sa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/c5sa_mac.sv =====
`default_nettype none
module c5sa_mac import c5sa_pkg::*; #(
  parameter int ACC_W = 37
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctrl_t                ctrl,
  input  wire logic                     sq_en,
  input  wire logic signed [DATA_W-1:0] wgt_rdata,
  input  wire logic signed [DATA_W-1:0] act_rdata,
  output logic                          busy,
  output logic        [RES_W-1:0]       res
);

  logic                     p1_valid_r;
  logic                     p1_keep_r;
  logic                     p2_valid_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic        [ACC_W-1:0]  mag;
  logic        [ACC_W-1:0]  mag_r;
  logic                     sat_r;
  logic        [RES_W-1:0]  sq_full;
  logic        [RES_W-1:0]  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= ctrl.issue;
      p2_valid_r <= p1_valid_r;
    end
  end

  // stage 1: read data arrives, multiply; taps off the image add zero
  always_ff @(posedge clk) begin
    p1_keep_r <= ctrl.in_image;
    prod_r    <= p1_keep_r ? PROD_W'(wgt_rdata * act_rdata) : '0;
  end

  // stage 2: accumulate
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (p2_valid_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  always_ff @(posedge clk) begin
    if (ctrl.sq) begin
      mag_r <= mag;
      sat_r <= RES_W'(mag) > SQ_LIMIT;
    end
  end

  assign sq_full = mag_r[31:0] * mag_r[31:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      if (!sq_en) begin
        res_r <= {{(RES_W-ACC_W){acc_r[ACC_W-1]}}, acc_r};
      end else if (sat_r) begin
        res_r <= INT64_MAX;
      end else begin
        res_r <= sq_full;
      end
    end
  end

  assign busy = p1_valid_r | p2_valid_r;
  assign res  = res_r;

  a_sq_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.sq |-> !busy)
    else $error("magnitude taken while products still in flight");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |-> !busy)
    else $error("sum cleared while products still in flight");

  a_mul_after_sq: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mul |-> $past(ctrl.sq))
    else $error("square taken without a fresh magnitude");

endmodule
`default_nettype wire

// ===== sv/c5sa_seq.sv =====
`default_nettype none
module c5sa_seq import c5sa_pkg::*; #(
  parameter int MAX_WIDTH        = 32,
  parameter int MAX_IN_CHANNELS  = 8,
  parameter int MAX_OUT_CHANNELS = 16,
  localparam int ACT_DEPTH = MAX_IN_CHANNELS * MAX_WIDTH * MAX_WIDTH,
  localparam int WGT_DEPTH = KSIZE * KSIZE * MAX_IN_CHANNELS * MAX_OUT_CHANNELS,
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1,
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  c5sa_in_if.sink                    in_ch,
  c5sa_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       wgt_we,
  output logic      [WGT_AW-1:0]     wgt_addr,
  output logic      [DATA_W-1:0]     wgt_wdata,
  output logic                       act_we,
  output logic      [ACT_AW-1:0]     act_addr,
  output logic      [DATA_W-1:0]     act_wdata,
  output mac_ctrl_t                  ctrl,
  output logic                       sq_en,
  input  wire logic                  mac_busy,
  input  wire logic [RES_W-1:0]      mac_res
);

  localparam int ZC_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;

  seq_state_t        state_r, state_nxt;
  logic [IMG_W-1:0]  img_w_r;
  logic [NIN_W-1:0]  nin_cfg_r;
  logic [NOUT_W-1:0] nout_cfg_r;
  logic              sq_en_r;
  logic [OCH_W-1:0]  oc_r;
  logic [POS_W-1:0]  row_r;
  logic [POS_W-1:0]  col_r;
  logic [ZC_W-1:0]   z_r, z_nxt;
  logic [TAP_W-1:0]  yy_r, yy_nxt;
  logic [TAP_W-1:0]  xx_r, xx_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r;
  logic [RES_W-1:0]  out_res_r;
  logic              out_err_r;
  logic              out_load;

  logic [IMG_W-1:0]  w_c;
  logic [NIN_W-1:0]  nin_c;
  logic [NOUT_W-1:0] nout_c;
  logic              accept;
  logic              req_err;
  logic              wgt_ok;
  logic              act_ok;
  logic              last_tap;
  logic signed [7:0] py, px;
  logic              tap_in;
  logic [ACT_AW-1:0] act_raddr, act_waddr;
  logic [WGT_AW-1:0] wgt_raddr, wgt_waddr;

  // registers above their maximum are clamped
  assign w_c    = (int'(img_w_r) > MAX_WIDTH) ? IMG_W'(MAX_WIDTH) : img_w_r;
  assign nin_c  = (int'(nin_cfg_r) > MAX_IN_CHANNELS) ? NIN_W'(MAX_IN_CHANNELS) : nin_cfg_r;
  assign nout_c = (int'(nout_cfg_r) > MAX_OUT_CHANNELS) ?
                  NOUT_W'(MAX_OUT_CHANNELS) : nout_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= RST_IMAGE_WIDTH;
      nin_cfg_r  <= RST_IN_CHANNELS;
      nout_cfg_r <= RST_OUT_CHANNELS;
      sq_en_r    <= RST_SQUARE_EN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r    <= cfg_data[IMG_W-1:0];
        CFG_IN_CHANNELS:  nin_cfg_r  <= cfg_data[NIN_W-1:0];
        CFG_OUT_CHANNELS: nout_cfg_r <= cfg_data[NOUT_W-1:0];
        CFG_SQUARE_EN:    sq_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sq_en = sq_en_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign req_err = ({1'b0, in_ch.out_chan} >= nout_c) ||
                   ({1'b0, in_ch.row} >= w_c) || ({1'b0, in_ch.col} >= w_c);

  assign wgt_ok = (int'(in_ch.tap_row) < KSIZE) && (int'(in_ch.tap_col) < KSIZE) &&
                  (int'(in_ch.in_chan) < MAX_IN_CHANNELS) &&
                  (int'(in_ch.out_chan) < MAX_OUT_CHANNELS);
  assign act_ok = (int'(in_ch.in_chan) < MAX_IN_CHANNELS) &&
                  (int'(in_ch.row) < MAX_WIDTH) && (int'(in_ch.col) < MAX_WIDTH);

  // tap position in the image, padded by two on each side
  assign py = $signed({3'b000, row_r}) + $signed({5'b00000, yy_r}) - $signed(8'(KPAD));
  assign px = $signed({3'b000, col_r}) + $signed({5'b00000, xx_r}) - $signed(8'(KPAD));
  assign tap_in = !py[7] && (py < $signed({2'b00, w_c})) &&
                  !px[7] && (px < $signed({2'b00, w_c}));

  assign act_raddr = tap_in ?
    ACT_AW'((int'(z_r) * MAX_WIDTH + int'(py[6:0])) * MAX_WIDTH + int'(px[6:0])) : '0;
  assign act_waddr =
    ACT_AW'((int'(in_ch.in_chan) * MAX_WIDTH + int'(in_ch.row)) * MAX_WIDTH +
            int'(in_ch.col));
  assign wgt_raddr =
    WGT_AW'(((int'(yy_r) * KSIZE + int'(xx_r)) * MAX_IN_CHANNELS + int'(z_r)) *
            MAX_OUT_CHANNELS + int'(oc_r));
  assign wgt_waddr =
    WGT_AW'(((int'(in_ch.tap_row) * KSIZE + int'(in_ch.tap_col)) * MAX_IN_CHANNELS +
             int'(in_ch.in_chan)) * MAX_OUT_CHANNELS + int'(in_ch.out_chan));

  assign wgt_we    = accept && (in_ch.func == FUNC_LOAD_WEIGHT) && wgt_ok;
  assign act_we    = accept && (in_ch.func == FUNC_LOAD_PIXEL) && act_ok;
  assign wgt_wdata = in_ch.data_value;
  assign act_wdata = in_ch.data_value;
  assign wgt_addr  = (state_r == ST_RUN) ? wgt_raddr : wgt_waddr;
  assign act_addr  = (state_r == ST_RUN) ? act_raddr : act_waddr;

  assign last_tap = (xx_r == TAP_W'(KSIZE - 1)) && (yy_r == TAP_W'(KSIZE - 1)) &&
                    (int'(z_r) == int'(nin_c) - 1);

  always_comb begin
    state_nxt = state_r;
    z_nxt     = z_r;
    yy_nxt    = yy_r;
    xx_nxt    = xx_r;
    err_nxt   = err_r;
    ctrl      = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_ch.func == FUNC_COMPUTE)) begin
          z_nxt  = '0;
          yy_nxt = '0;
          xx_nxt = '0;
          if (req_err) begin
            err_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            err_nxt    = 1'b0;
            ctrl.clear = 1'b1;
            // no input channels in use gives a sum of zero
            state_nxt  = (nin_c == '0) ? ST_DRAIN : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ctrl.issue    = 1'b1;
        ctrl.in_image = tap_in;
        if (xx_r == TAP_W'(KSIZE - 1)) begin
          xx_nxt = '0;
          if (yy_r == TAP_W'(KSIZE - 1)) begin
            yy_nxt = '0;
            z_nxt  = z_r + 1'b1;
          end else begin
            yy_nxt = yy_r + 1'b1;
          end
        end else begin
          xx_nxt = xx_r + 1'b1;
        end
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        ctrl.sq   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      z_r     <= '0;
      yy_r    <= '0;
      xx_r    <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      z_r     <= z_nxt;
      yy_r    <= yy_nxt;
      xx_r    <= xx_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      oc_r  <= in_ch.out_chan;
      row_r <= in_ch.row;
      col_r <= in_ch.col;
    end
  end

  // output register: new items are taken while a result waits here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= err_r ? '0 : mac_res;
      out_err_r <= err_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.range_error  = out_err_r;

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.issue |-> (!wgt_we && !act_we))
    else $error("store written during a tap sweep");

  a_tap_in_kernel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((xx_r < TAP_W'(KSIZE)) && (yy_r < TAP_W'(KSIZE))))
    else $error("tap counter left the kernel");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_ch.valid && (out_ch.range_error == $past(err_r))))
    else $error("finished item not presented at the output");

endmodule
`default_nettype wire

// ===== sv/conv5x5_same_square_activation_top.sv =====
// 5x5 multichannel convolution with zero padding of two, then optional squaring.
// in_ch (valid/ready) carries items: func selects a weight load, a pixel load or
// a compute request at (out_chan, row, col). out_ch (valid/ready) carries one
// result per compute request: result_value and range_error. Loads give none.
// cfg_we/cfg_index/cfg_data write image_width, in_channel_count,
// out_channel_count and square_enable; the user must write them only while
// the block is idle, as the block itself does not enforce it. A load is
// written to its RAM as it is accepted, and the block stays ready. A compute
// request runs one multiply-accumulate per kernel tap, fed by one read port
// on the weight RAM and one on the activation RAM, then a drain of the
// multiply pipeline and the magnitude and squaring states. A request that
// is out of range skips straight to the output, and an in_channel_count of
// zero gives the empty sum after the drain. Taps off the image are swept too.
// The result sits in an output register; while the receiver stalls, loads and
// a following request are still taken, and only the hand-over of the next
// result waits. Reset sets the registers to their defaults and empties the
// pipeline; both RAMs keep undefined contents until written.
`default_nettype none
module conv5x5_same_square_activation_top import c5sa_pkg::*; #(
  parameter int MAX_WIDTH        = 32,
  parameter int MAX_IN_CHANNELS  = 8,
  parameter int MAX_OUT_CHANNELS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  c5sa_in_if.sink                    in_ch,
  c5sa_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ACT_DEPTH = MAX_IN_CHANNELS * MAX_WIDTH * MAX_WIDTH;
  localparam int WGT_DEPTH = KSIZE * KSIZE * MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int ACC_W     = PROD_W + $clog2(KSIZE * KSIZE * MAX_IN_CHANNELS + 1);

  logic              wgt_we;
  logic [WGT_AW-1:0] wgt_addr;
  logic [DATA_W-1:0] wgt_wdata;
  logic [DATA_W-1:0] wgt_rdata;
  logic              act_we;
  logic [ACT_AW-1:0] act_addr;
  logic [DATA_W-1:0] act_wdata;
  logic [DATA_W-1:0] act_rdata;
  mac_ctrl_t         ctrl;
  logic              sq_en;
  logic              mac_busy;
  logic [RES_W-1:0]  mac_res;

  c5sa_seq #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wgt_we    (wgt_we),
    .wgt_addr  (wgt_addr),
    .wgt_wdata (wgt_wdata),
    .act_we    (act_we),
    .act_addr  (act_addr),
    .act_wdata (act_wdata),
    .ctrl      (ctrl),
    .sq_en     (sq_en),
    .mac_busy  (mac_busy),
    .mac_res   (mac_res)
  );

  c5sa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .addr  (wgt_addr),
    .wdata (wgt_wdata),
    .rdata (wgt_rdata)
  );

  c5sa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ACT_DEPTH)
  ) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .addr  (act_addr),
    .wdata (act_wdata),
    .rdata (act_rdata)
  );

  c5sa_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sq_en     (sq_en),
    .wgt_rdata ($signed(wgt_rdata)),
    .act_rdata ($signed(act_rdata)),
    .busy      (mac_busy),
    .res       (mac_res)
  );

endmodule
`default_nettype wire
